// ===== design/atpb_pkg.sv =====
// Shared constants, types and codes for the area trigger polygon/box unit.
// No dependencies; every design file refers to this package by scoped names.
package atpb_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_VERTICES = 64;
  localparam int MIN_VERTICES = 3;

  localparam int VIDX_W    = $clog2(MAX_VERTICES);
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int VCOUNT_W  = 7;
  localparam int VINDEX_W  = 6;
  localparam int BOX_W     = 3 * COORD_BITS;
  localparam int CFG_W     = BOX_W;
  localparam int CFG_IDX_W = 3;
  localparam int VERT_W    = 2 * COORD_BITS;
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_ENABLED = 3'd0,
    REG_OBJECT_ACTIVE   = 3'd1,
    REG_POLY_MODE       = 3'd2,
    REG_HEIGHT_MIN      = 3'd3,
    REG_HEIGHT_MAX      = 3'd4,
    REG_VERTEX_COUNT    = 3'd5,
    REG_BOX_LOW         = 3'd6,
    REG_BOX_HIGH        = 3'd7
  } cfg_reg_t;

  typedef enum logic [0:0] {
    TOP_IDLE,
    TOP_CAST
  } top_state_t;

  typedef enum logic [2:0] {
    RC_IDLE,
    RC_PRIME,
    RC_FETCH,
    RC_MUL_A,
    RC_MUL_B,
    RC_CMP
  } rc_state_t;

  // launch of a ray cast
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] count;
    coord_t           px;
    coord_t           pz;
  } rc_ctrl_t;

  // finish of a ray cast
  typedef struct packed {
    logic done;
    logic in_poly;
  } rc_stat_t;

  // vertex table write
  typedef struct packed {
    logic              en;
    logic [VIDX_W-1:0] addr;
    coord_t            x;
    coord_t            z;
  } vt_wr_t;

endpackage

// ===== design/area_trigger_polygon_box_unit.sv =====
// Area trigger: polygon (with height range) or box containment, enter/exit marks.
// Depends on atpb_pkg and atpb_ray_cast.
// Sequence: loads, disabled queries, box queries and rejected polygon queries
//   give their result beat in the cycle after they are accepted; a polygon ray cast over n
//   vertices runs one vertex-table read prime, then fetch, two multiplies and a
//   compare per edge on the single shared 17x17 multiplier.
// Throughput: one item per result; busy stays high while a ray cast runs.
// Reset (rst, synchronous): registers to their documented values, inside flag
//   cleared; the vertex table is not cleared. The receiver cannot stall: done
//   marks each result beat for exactly one cycle.
module area_trigger_polygon_box_unit (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  atpb_pkg::coord_t                pos_x,
  input  atpb_pkg::coord_t                pos_y,
  input  atpb_pkg::coord_t                pos_z,
  input  logic [atpb_pkg::VINDEX_W-1:0]   vertex_index,
  input  atpb_pkg::coord_t                vertex_x,
  input  atpb_pkg::coord_t                vertex_z,
  // result channel
  output logic                            done,
  output logic                            inside_now,
  output logic                            entered,
  output logic                            exited,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [atpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atpb_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CB = atpb_pkg::COORD_BITS;

  // configuration registers
  logic                          trigger_enabled;
  logic                          object_active;
  logic                          poly_mode;
  atpb_pkg::coord_t              height_min;
  atpb_pkg::coord_t              height_max;
  logic [atpb_pkg::VCOUNT_W-1:0] vertex_count;
  logic [atpb_pkg::BOX_W-1:0]    box_low_corner;
  logic [atpb_pkg::BOX_W-1:0]    box_high_corner;

  logic inside_flag;

  atpb_pkg::top_state_t state, state_next;
  atpb_pkg::rc_ctrl_t   rc_ctrl;
  atpb_pkg::rc_stat_t   rc_stat;
  atpb_pkg::vt_wr_t     vwr;

  logic accept, is_load, enabled, height_ok, count_ok, box_in, launch, slot_ok;
  logic report, update, rep_now, cast_go, vt_en;
  logic [atpb_pkg::CNT_W-1:0] n_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_enabled <= 1'b0;
      object_active   <= 1'b0;
      poly_mode       <= 1'b0;
      height_min      <= {1'b1, {(CB-1){1'b0}}};
      height_max      <= {1'b0, {(CB-1){1'b1}}};
      vertex_count    <= '0;
      box_low_corner  <= '0;
      box_high_corner <= '0;
    end else if (cfg_write) begin
      case (atpb_pkg::cfg_reg_t'(cfg_index))
        atpb_pkg::REG_TRIGGER_ENABLED: trigger_enabled <= cfg_data[0];
        atpb_pkg::REG_OBJECT_ACTIVE:   object_active   <= cfg_data[0];
        atpb_pkg::REG_POLY_MODE:       poly_mode       <= cfg_data[0];
        atpb_pkg::REG_HEIGHT_MIN:      height_min      <= atpb_pkg::coord_t'(cfg_data[CB-1:0]);
        atpb_pkg::REG_HEIGHT_MAX:      height_max      <= atpb_pkg::coord_t'(cfg_data[CB-1:0]);
        atpb_pkg::REG_VERTEX_COUNT:    vertex_count    <= cfg_data[atpb_pkg::VCOUNT_W-1:0];
        atpb_pkg::REG_BOX_LOW:         box_low_corner  <= cfg_data[atpb_pkg::BOX_W-1:0];
        atpb_pkg::REG_BOX_HIGH:        box_high_corner <= cfg_data[atpb_pkg::BOX_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy    = (state == atpb_pkg::TOP_CAST);
  assign accept  = start && !busy;
  assign is_load = (command == atpb_pkg::CMD_LOAD);
  assign enabled = trigger_enabled && object_active;

  // inclusive height band for polygon mode
  assign height_ok = (pos_y >= height_min) && (pos_y <= height_max);

  // count above table depth is clamped to the depth
  assign n_use = (32'(vertex_count) > atpb_pkg::MAX_VERTICES)
               ? atpb_pkg::CNT_W'(atpb_pkg::MAX_VERTICES)
               : atpb_pkg::CNT_W'(vertex_count);
  assign count_ok = (32'(n_use) >= atpb_pkg::MIN_VERTICES);

  // inclusive box test, x/y/z packed low to high; an inverted range holds nothing
  assign box_in =
      (pos_x >= $signed(box_low_corner[0*CB +: CB])) &&
      (pos_x <= $signed(box_high_corner[0*CB +: CB])) &&
      (pos_y >= $signed(box_low_corner[1*CB +: CB])) &&
      (pos_y <= $signed(box_high_corner[1*CB +: CB])) &&
      (pos_z >= $signed(box_low_corner[2*CB +: CB])) &&
      (pos_z <= $signed(box_high_corner[2*CB +: CB]));

  assign launch  = enabled && poly_mode && height_ok && count_ok;
  assign slot_ok = (32'(vertex_index) < atpb_pkg::MAX_VERTICES);

  assign rc_ctrl = {cast_go, n_use, pos_x, pos_z};
  assign vwr     = {vt_en, atpb_pkg::VIDX_W'(vertex_index), vertex_x, vertex_z};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      atpb_pkg::TOP_IDLE: begin
        if (accept && !is_load && launch) state_next = atpb_pkg::TOP_CAST;
      end
      atpb_pkg::TOP_CAST: begin
        if (rc_stat.done) state_next = atpb_pkg::TOP_IDLE;
      end
      default: state_next = atpb_pkg::TOP_IDLE;
    endcase
  end

  // outputs: report gives a result beat next cycle, update moves the inside flag
  always_comb begin
    report  = 1'b0;
    update  = 1'b0;
    rep_now = 1'b0;
    cast_go = 1'b0;
    vt_en   = 1'b0;
    case (state)
      atpb_pkg::TOP_IDLE: begin
        if (accept) begin
          if (is_load) begin
            report = 1'b1;
            vt_en  = slot_ok;
          end else if (!enabled) begin
            report = 1'b1;
          end else if (!poly_mode) begin
            report  = 1'b1;
            update  = 1'b1;
            rep_now = box_in;
          end else if (launch) begin
            cast_go = 1'b1;
          end else begin
            // outside the height band or too few vertices
            report = 1'b1;
            update = 1'b1;
          end
        end
      end
      atpb_pkg::TOP_CAST: begin
        if (rc_stat.done) begin
          report  = 1'b1;
          update  = 1'b1;
          rep_now = rc_stat.in_poly;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= atpb_pkg::TOP_IDLE;
      done        <= 1'b0;
      inside_now  <= 1'b0;
      entered     <= 1'b0;
      exited      <= 1'b0;
      inside_flag <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= report;
      inside_now <= rep_now;
      entered    <= update && rep_now && !inside_flag;
      exited     <= update && !rep_now && inside_flag;
      if (update) begin
        inside_flag <= rep_now;
      end
    end
  end

  atpb_ray_cast u_ray_cast (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rc_ctrl),
    .wr   (vwr),
    .stat (rc_stat)
  );

endmodule

// ===== design/atpb_ray_cast.sv =====
// Vertex table and even-odd ray cast sequencer with one shared multiplier.
// Depends on atpb_pkg.
module atpb_ray_cast (
  input  logic             clk,
  input  logic             rst,
  input  atpb_pkg::rc_ctrl_t ctrl,
  input  atpb_pkg::vt_wr_t   wr,
  output atpb_pkg::rc_stat_t stat
);

  atpb_pkg::rc_state_t state, state_next;

  logic [atpb_pkg::VERT_W-1:0] vtab [atpb_pkg::MAX_VERTICES];
  logic [atpb_pkg::VERT_W-1:0] rd_data;
  logic [atpb_pkg::VIDX_W-1:0] rd_addr;

  atpb_pkg::coord_t pos_x_q, pos_z_q, prev_x, prev_z, cur_x, cur_z;
  logic [atpb_pkg::CNT_W-1:0] cnt, ptr;
  atpb_pkg::diff_t dx, span, ex, dz, mul_a, mul_b;
  atpb_pkg::prod_t prod_a, prod_b, mul_out;
  logic crossing, parity, hit, last;

  assign cur_x = atpb_pkg::coord_t'(rd_data[atpb_pkg::COORD_BITS-1:0]);
  assign cur_z = atpb_pkg::coord_t'(rd_data[atpb_pkg::VERT_W-1:atpb_pkg::COORD_BITS]);

  // closing edge first: prime with the last vertex, then walk from slot 0
  always_comb begin
    if (state == atpb_pkg::RC_IDLE) begin
      rd_addr = atpb_pkg::VIDX_W'(ctrl.count - atpb_pkg::CNT_W'(1));
    end else begin
      rd_addr = ptr[atpb_pkg::VIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      vtab[wr.addr] <= {wr.z, wr.x};
    end
    rd_data <= vtab[rd_addr];
  end

  assign mul_out = mul_a * mul_b;
  assign last    = (ptr == cnt);
  // sign of the z span picks the direction of the cross-multiplied compare
  assign hit     = span[atpb_pkg::DIFF_W-1] ? (prod_a > prod_b) : (prod_a < prod_b);

  always_comb begin
    state_next = state;
    case (state)
      atpb_pkg::RC_IDLE:  if (ctrl.go) state_next = atpb_pkg::RC_PRIME;
      atpb_pkg::RC_PRIME: state_next = atpb_pkg::RC_FETCH;
      atpb_pkg::RC_FETCH: state_next = atpb_pkg::RC_MUL_A;
      atpb_pkg::RC_MUL_A: state_next = atpb_pkg::RC_MUL_B;
      atpb_pkg::RC_MUL_B: state_next = atpb_pkg::RC_CMP;
      atpb_pkg::RC_CMP:   state_next = last ? atpb_pkg::RC_IDLE : atpb_pkg::RC_FETCH;
      default:            state_next = atpb_pkg::RC_IDLE;
    endcase
  end

  always_comb begin
    mul_a        = dx;
    mul_b        = span;
    stat.done    = 1'b0;
    stat.in_poly = parity;
    case (state)
      atpb_pkg::RC_MUL_B: begin
        mul_a = ex;
        mul_b = dz;
      end
      atpb_pkg::RC_CMP: begin
        stat.done    = last;
        stat.in_poly = parity ^ (crossing & hit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atpb_pkg::RC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      atpb_pkg::RC_IDLE: begin
        if (ctrl.go) begin
          pos_x_q <= ctrl.px;
          pos_z_q <= ctrl.pz;
          cnt     <= ctrl.count;
          ptr     <= '0;
          parity  <= 1'b0;
        end
      end
      atpb_pkg::RC_PRIME: begin
        prev_x <= cur_x;
        prev_z <= cur_z;
      end
      atpb_pkg::RC_FETCH: begin
        crossing <= (cur_z > pos_z_q) != (prev_z > pos_z_q);
        dx       <= atpb_pkg::diff_t'(pos_x_q) - atpb_pkg::diff_t'(cur_x);
        span     <= atpb_pkg::diff_t'(prev_z) - atpb_pkg::diff_t'(cur_z);
        ex       <= atpb_pkg::diff_t'(prev_x) - atpb_pkg::diff_t'(cur_x);
        dz       <= atpb_pkg::diff_t'(pos_z_q) - atpb_pkg::diff_t'(cur_z);
        prev_x   <= cur_x;
        prev_z   <= cur_z;
      end
      atpb_pkg::RC_MUL_A: begin
        prod_a <= mul_out;
        ptr    <= ptr + atpb_pkg::CNT_W'(1);
      end
      atpb_pkg::RC_MUL_B: begin
        prod_b <= mul_out;
      end
      atpb_pkg::RC_CMP: begin
        parity <= parity ^ (crossing & hit);
      end
      default: ;
    endcase
  end

endmodule

// ===== test/atpb_trigger_sb_pkg.sv =====
// Scoreboard for the area trigger unit: beat types, a bit-exact predictor of the
// containment test and the queue of outstanding enter/exit marks.
// Depends on atpb_pkg for coordinate types, command codes and register indexes.
`timescale 1ns / 1ps

package atpb_trigger_sb_pkg;

  import atpb_pkg::*;

  typedef struct {
    logic                command;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              pos_z;
    logic [VINDEX_W-1:0] vertex_index;
    coord_t              vertex_x;
    coord_t              vertex_z;
  } trigger_item_t;

  typedef struct packed {
    logic inside_now;
    logic entered;
    logic exited;
  } trigger_marks_t;

  class containment_scoreboard;
    bit                  trig_en;
    bit                  obj_act;
    bit                  poly;
    coord_t              hmin;
    coord_t              hmax;
    logic [VCOUNT_W-1:0] vcount;
    logic [BOX_W-1:0]    box_lo;
    logic [BOX_W-1:0]    box_hi;
    coord_t              vx [MAX_VERTICES];
    coord_t              vz [MAX_VERTICES];
    bit                  was_inside;
    trigger_marks_t      pending_marks [$];
    int                  errors;

    function new();
      trig_en    = 1'b0;
      obj_act    = 1'b0;
      poly       = 1'b0;
      hmin       = {1'b1, {(COORD_BITS-1){1'b0}}};
      hmax       = {1'b0, {(COORD_BITS-1){1'b1}}};
      vcount     = '0;
      box_lo     = '0;
      box_hi     = '0;
      was_inside = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_TRIGGER_ENABLED: trig_en = v[0];
        REG_OBJECT_ACTIVE:   obj_act = v[0];
        REG_POLY_MODE:       poly    = v[0];
        REG_HEIGHT_MIN:      hmin    = coord_t'(v[COORD_BITS-1:0]);
        REG_HEIGHT_MAX:      hmax    = coord_t'(v[COORD_BITS-1:0]);
        REG_VERTEX_COUNT:    vcount  = v[VCOUNT_W-1:0];
        REG_BOX_LOW:         box_lo  = v[BOX_W-1:0];
        REG_BOX_HIGH:        box_hi  = v[BOX_W-1:0];
      endcase
    endfunction

    // even-odd crossing count; crossing abscissa compared by cross multiplication
    function bit poly_contains(coord_t px, coord_t pz);
      int     n;
      int     i;
      int     j;
      longint x0, z0, x1, z1, dz, lhs, rhs, qx, qz;
      bit     odd;
      n   = (int'(vcount) > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
      odd = 1'b0;
      if (n < MIN_VERTICES) return 1'b0;
      qx = longint'(px);
      qz = longint'(pz);
      j  = n - 1;
      for (i = 0; i < n; i++) begin
        x0 = longint'(vx[i]);
        z0 = longint'(vz[i]);
        x1 = longint'(vx[j]);
        z1 = longint'(vz[j]);
        if ((z0 > qz) != (z1 > qz)) begin
          dz  = z1 - z0;
          lhs = (qx - x0) * dz;
          rhs = (x1 - x0) * (qz - z0);
          if (dz > 0 ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
        end
        j = i;
      end
      return odd;
    endfunction

    function bit box_contains(coord_t px, coord_t py, coord_t pz);
      coord_t p [3];
      coord_t lo;
      coord_t hi;
      int     k;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      for (k = 0; k < 3; k++) begin
        lo = coord_t'(box_lo[k*COORD_BITS +: COORD_BITS]);
        hi = coord_t'(box_hi[k*COORD_BITS +: COORD_BITS]);
        if (p[k] < lo || p[k] > hi) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(trigger_item_t it);
      trigger_marks_t m;
      bit             now;
      m   = '0;
      now = 1'b0;
      if (it.command == CMD_LOAD) begin
        vx[it.vertex_index] = it.vertex_x;
        vz[it.vertex_index] = it.vertex_z;
      end else if (trig_en && obj_act) begin
        if (poly)
          now = (it.pos_y >= hmin) && (it.pos_y <= hmax) && poly_contains(it.pos_x, it.pos_z);
        else
          now = box_contains(it.pos_x, it.pos_y, it.pos_z);
        m.inside_now = now;
        m.entered    = now && !was_inside;
        m.exited     = !now && was_inside;
        was_inside   = now;
      end
      pending_marks.push_back(m);
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic in_now, logic ent, logic ext);
      trigger_marks_t want;
      if (pending_marks.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none actual %0b%0b%0b",
                 $time, in_now, ent, ext);
        errors++;
        return;
      end
      want = pending_marks.pop_front();
      compare_bit("inside_now", want.inside_now, in_now);
      compare_bit("entered", want.entered, ent);
      compare_bit("exited", want.exited, ext);
    endfunction
  endclass

endpackage

// ===== test/tb_area_trigger_polygon_box_unit.sv =====
// Testbench for area_trigger_polygon_box_unit: directed and random command beats,
// results checked against a scoreboard model of the polygon/box containment test.
// Depends on atpb_pkg and atpb_trigger_sb_pkg.
`timescale 1ns / 1ps

module tb_area_trigger_polygon_box_unit;

  import atpb_pkg::*;
  import atpb_trigger_sb_pkg::*;

  // slowest legal run is well under this: every query a full-table cast plus gaps
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          PHASES      = 16;
  localparam int          FULL_SPAN   = 32767;

  typedef struct {
    bit                  trig_en;
    bit                  obj_act;
    bit                  poly;
    coord_t              hmin;
    coord_t              hmax;
    logic [VCOUNT_W-1:0] vcount;
    logic [BOX_W-1:0]    box_lo;
    logic [BOX_W-1:0]    box_hi;
  } trigger_setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 command = CMD_QUERY;
  coord_t               pos_x = '0;
  coord_t               pos_y = '0;
  coord_t               pos_z = '0;
  logic [VINDEX_W-1:0]  vertex_index = '0;
  coord_t               vertex_x = '0;
  coord_t               vertex_z = '0;
  logic                 done;
  logic                 inside_now;
  logic                 entered;
  logic                 exited;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  containment_scoreboard board;
  bit                    sender_idles = 1'b1;
  int unsigned           cycle_count = 0;

  area_trigger_polygon_box_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .vertex_index (vertex_index),
    .vertex_x     (vertex_x),
    .vertex_z     (vertex_z),
    .done         (done),
    .inside_now   (inside_now),
    .entered      (entered),
    .exited       (exited),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // Result beats can't be held off: sample done on every edge. Values read here
  // are the pre-edge ones, since the block's updates land in the NBA region.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(inside_now, entered, exited);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [BOX_W-1:0] pack_xyz(coord_t x, coord_t y, coord_t z);
    return {z, y, x};
  endfunction

  // Random coordinate within +/- span; full span also hits the two extremes often.
  function automatic coord_t rand_coord(int span);
    int r;
    if (span >= FULL_SPAN) begin
      r = int'($urandom_range(9));
      if (r == 0) return coord_t'(16'sh8000);
      if (r == 1) return coord_t'(16'sh7fff);
      return coord_t'($urandom);
    end
    return coord_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // Value near an inclusive [lo, hi] range: on both bounds, just outside, within, or anywhere.
  function automatic coord_t pick_near(coord_t lo, coord_t hi);
    case ($urandom_range(9))
      0:       return lo;
      1:       return hi;
      2:       return lo - coord_t'(1);
      3:       return hi + coord_t'(1);
      4:       return coord_t'($urandom);
      default: begin
        if (lo <= hi) return coord_t'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
        return coord_t'($urandom);
      end
    endcase
  endfunction

  // Sender gaps: idle with a chance of 27 in a hundred, again after each idle, unless idling is switched off.
  task automatic sender_gap();
    while (sender_idles && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One command beat; returns just after the accepting edge with start left high,
  // so back-to-back beats never lower and raise start in the same step.
  task automatic send(trigger_item_t it);
    sender_gap();
    start        <= 1'b1;
    command      <= it.command;
    pos_x        <= it.pos_x;
    pos_y        <= it.pos_y;
    pos_z        <= it.pos_z;
    vertex_index <= it.vertex_index;
    vertex_x     <= it.vertex_x;
    vertex_z     <= it.vertex_z;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(it);
  endtask

  // Unused fields carry junk so that every input bit moves.
  task automatic query(coord_t x, coord_t y, coord_t z);
    trigger_item_t it;
    it.command      = CMD_QUERY;
    it.pos_x        = x;
    it.pos_y        = y;
    it.pos_z        = z;
    it.vertex_index = VINDEX_W'($urandom);
    it.vertex_x     = coord_t'($urandom);
    it.vertex_z     = coord_t'($urandom);
    send(it);
  endtask

  task automatic load_vertex(int idx, coord_t x, coord_t z);
    trigger_item_t it;
    it.command      = CMD_LOAD;
    it.pos_x        = coord_t'($urandom);
    it.pos_y        = coord_t'($urandom);
    it.pos_z        = coord_t'($urandom);
    it.vertex_index = VINDEX_W'(idx);
    it.vertex_x     = x;
    it.vertex_z     = z;
    send(it);
  endtask

  // Drop start and wait until every outstanding mark has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_marks.size() != 0 || busy);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    board.set_reg(idx, v);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic configure(trigger_setting_t s);
    write_reg(REG_TRIGGER_ENABLED, CFG_W'(s.trig_en));
    write_reg(REG_OBJECT_ACTIVE, CFG_W'(s.obj_act));
    write_reg(REG_POLY_MODE, CFG_W'(s.poly));
    write_reg(REG_HEIGHT_MIN, CFG_W'($unsigned(s.hmin)));
    write_reg(REG_HEIGHT_MAX, CFG_W'($unsigned(s.hmax)));
    write_reg(REG_VERTEX_COUNT, CFG_W'(s.vcount));
    write_reg(REG_BOX_LOW, CFG_W'(s.box_lo));
    write_reg(REG_BOX_HIGH, CFG_W'(s.box_hi));
  endtask

  task automatic run_directed();
    trigger_setting_t s;
    // reset config: both enables low, so this reports outside
    query(16'sh0000, 16'sh0000, 16'sh0000);
    // 200 x 200 square on x,z
    load_vertex(0, -100, -100);
    load_vertex(1, 100, -100);
    load_vertex(2, 100, 100);
    load_vertex(3, -100, 100);
    settle();
    s.trig_en = 1'b1;
    s.obj_act = 1'b1;
    s.poly    = 1'b1;
    s.hmin    = -10;
    s.hmax    = 10;
    s.vcount  = VCOUNT_W'(4);
    s.box_lo  = pack_xyz(-5, -5, -5);
    s.box_hi  = pack_xyz(5, 5, 5);
    configure(s);
    query(0, 0, 0);             // enter
    query(50, 10, -50);         // stay inside, top of height range
    query(0, 11, 0);            // above height range: exit
    query(0, -10, 0);           // bottom of height range
    query(-100, 0, -100);       // on a vertex
    query(100, 0, 0);           // on the right edge
    query(0, 0, 100);           // on the far edge
    query(16'sh8000, 16'sh8000, 16'sh8000);
    query(16'sh7fff, 10, 16'sh7fff);
    settle();
    s.trig_en = 1'b0;           // trigger disabled: marks held
    configure(s);
    query(0, 0, 0);
    settle();
    s.trig_en = 1'b1;
    s.obj_act = 1'b0;           // owner inactive
    configure(s);
    query(0, 0, 0);
    settle();
    s.obj_act = 1'b1;
    s.vcount  = VCOUNT_W'(2);   // too few vertices for a polygon
    configure(s);
    query(0, 0, 0);
    settle();
    s.vcount = VCOUNT_W'(4);
    s.hmin   = 5;               // empty height range
    s.hmax   = -5;
    configure(s);
    query(0, 0, 0);
    settle();
    s.poly = 1'b0;              // box mode, inclusive corners
    configure(s);
    query(-5, -5, -5);
    query(5, 5, 5);
    query(6, 0, 0);
    query(0, -6, 0);
    query(0, 0, 5);
    settle();
    s.box_lo = pack_xyz(5, -5, -5);   // empty along x
    s.box_hi = pack_xyz(-5, 5, 5);
    configure(s);
    query(0, 0, 0);
    settle();
    s.box_lo = pack_xyz(16'sh8000, 16'sh8000, 16'sh8000);
    s.box_hi = pack_xyz(16'sh7fff, 16'sh7fff, 16'sh7fff);
    configure(s);
    query(16'sh8000, 16'sh7fff, 16'sh8000);
    settle();
  endtask

  // One random setting followed by a burst of beats. Even phases run the polygon
  // test on a freshly loaded shape, odd phases the box test. Slots 0..nv-1 are
  // always loaded before any query, so no unwritten vertex is ever read.
  task automatic run_phase(int ph);
    trigger_setting_t s;
    int               span;
    int               nv;
    int               nq;
    int               k;
    coord_t           a;
    coord_t           b;
    coord_t           t;
    coord_t           lo [3];
    coord_t           hi [3];
    coord_t           x;
    coord_t           z;
    case ($urandom_range(2))
      0:       span = 8;          // tiny grid: lots of exact boundary hits
      1:       span = 1000;
      default: span = FULL_SPAN;
    endcase
    if (ph == 2) span = FULL_SPAN;
    sender_idles = (ph != 5);     // one long stretch with no gaps
    s.trig_en = ($urandom_range(99) < 90);
    s.obj_act = ($urandom_range(99) < 90);
    s.poly    = (ph % 2 == 0);
    // height range: full, random, or now and then empty
    if ($urandom_range(3) == 0 || ph == 1 || ph == 3) begin
      s.hmin = coord_t'(16'sh8000);
      s.hmax = coord_t'(16'sh7fff);
    end else begin
      a = rand_coord(span);
      b = rand_coord(span);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if ($urandom_range(9) == 0) begin
        s.hmin = b;
        s.hmax = a;
      end else begin
        s.hmin = a;
        s.hmax = b;
      end
    end
    // box corners per axis, likewise
    for (k = 0; k < 3; k++) begin
      a = rand_coord(span);
      b = rand_coord(span);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if ($urandom_range(9) == 0) begin
        lo[k] = b;
        hi[k] = a;
      end else begin
        lo[k] = a;
        hi[k] = b;
      end
      if (ph == 1) begin
        lo[k] = coord_t'(16'sh8000);
        hi[k] = coord_t'(16'sh7fff);
      end
    end
    s.box_lo = pack_xyz(lo[0], lo[1], lo[2]);
    s.box_hi = pack_xyz(hi[0], hi[1], hi[2]);
    // vertex count: mostly small shapes, one medium-sized phase, a few full tables
    if (ph == 0 || ph == 2)
      nv = MAX_VERTICES;
    else if (ph == 10)
      nv = int'($urandom_range(13, 40));
    else
      nv = int'($urandom_range(3, 12));
    s.vcount = VCOUNT_W'(nv);
    if (ph == 2) s.vcount = {VCOUNT_W{1'b1}};     // beyond the table, clamped
    if (ph == 6) s.vcount = VCOUNT_W'($urandom_range(2));
    configure(s);

    if (s.poly) begin
      for (k = 0; k < nv; k++) load_vertex(k, rand_coord(span), rand_coord(span));
    end
    nq = (s.poly && nv > 16) ? 15 : 40;
    for (k = 0; k < nq; k++) begin
      // hold off until the block has drained, now and then
      if ((ph == 3 && k == nq / 2) || $urandom_range(99) < 2) settle();
      if ($urandom_range(99) < 8) begin
        // stray vertex write; may reshape the live polygon
        load_vertex(int'($urandom_range(MAX_VERTICES - 1)), rand_coord(span), rand_coord(span));
      end else if (s.poly) begin
        case ($urandom_range(9))
          0, 1:    x = board.vx[$urandom_range(nv - 1)];
          2:       x = coord_t'($urandom);
          default: x = rand_coord(span);
        endcase
        case ($urandom_range(9))
          0, 1:    z = board.vz[$urandom_range(nv - 1)];
          2:       z = coord_t'($urandom);
          default: z = rand_coord(span);
        endcase
        query(x, pick_near(s.hmin, s.hmax), z);
      end else begin
        query(pick_near(lo[0], hi[0]), pick_near(lo[1], hi[1]), pick_near(lo[2], hi[2]));
      end
    end
    settle();
  endtask

  initial begin
    int ph;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (ph = 0; ph < PHASES; ph++) run_phase(ph);
    settle();
    // a full-length cast worth of quiet, to catch any stray result beat
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending_marks.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
